// File: rtl/core/dmv_pkg.sv
package dmv_pkg;

  localparam int unsigned MAX_COLUMNS = 1024;
  localparam int unsigned MAX_ROWS    = 4096;

  localparam int unsigned COL_CNT_W = 11;
  localparam int unsigned ROW_CNT_W = 13;
  localparam int unsigned COL_IDX_W = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_IDX_W = 12;

  localparam int unsigned ELEM_W  = 24;
  localparam int unsigned PROD_W  = 2 * ELEM_W;
  localparam int unsigned ACC_W   = 58;
  localparam int unsigned FRAC_W  = 23;
  localparam int unsigned RND_W   = ACC_W - FRAC_W;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned TOTAL_W = RND_W + 1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    RegColumnCount   = 2'd0,
    RegRowCount      = 2'd1,
    RegAccumulate    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CmdLoadVector   = 1'b0,
    CmdMatrixElem   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     command;
    logic signed [ELEM_W-1:0] value;
    logic signed [OUT_W-1:0]  prior_output;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] row_sum;
    logic [ROW_IDX_W-1:0]    row_index;
    logic                    final_row;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic                 last_col;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 final_row;
    logic signed [OUT_W-1:0] prior_output;
  } row_tag_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] matrix_value;
    logic signed [ELEM_W-1:0] vector_value;
    row_tag_t                 tag;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/dmv_front.sv
module dmv_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  dmv_pkg::in_item_t           in_data_i,
  input  logic [dmv_pkg::COL_CNT_W-1:0] column_count_i,
  input  logic [dmv_pkg::ROW_CNT_W-1:0] row_count_i,
  input  dmv_pkg::q_status_t          q_status_i,
  output dmv_pkg::q_push_t            q_push_o
);
  import dmv_pkg::*;

  logic [ELEM_W-1:0]    vec_mem [MAX_COLUMNS];
  logic [ELEM_W-1:0]    rdata_q;
  logic                 fr_valid_q;
  logic                 fr_valid_d;
  logic signed [ELEM_W-1:0] fr_value_q;
  row_tag_t             fr_tag_q;
  row_tag_t             tag_d;
  logic [COL_IDX_W-1:0] load_pos_q, load_pos_d;
  logic [COL_IDX_W-1:0] col_pos_q, col_pos_d;
  logic [ROW_IDX_W-1:0] row_pos_q, row_pos_d;
  logic [COL_CNT_W-1:0] cols_eff;
  logic [ROW_CNT_W-1:0] rows_eff;
  logic                 accept;
  logic                 push;
  logic                 is_matrix;
  logic                 last_col;
  logic                 final_row;

  always_comb begin
    if (column_count_i == '0) begin
      cols_eff = COL_CNT_W'(1);
    end else if (column_count_i > COL_CNT_W'(MAX_COLUMNS)) begin
      cols_eff = COL_CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = column_count_i;
    end
    if (row_count_i == '0) begin
      rows_eff = ROW_CNT_W'(1);
    end else if (row_count_i > ROW_CNT_W'(MAX_ROWS)) begin
      rows_eff = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count_i;
    end
  end

  always_comb begin
    push       = fr_valid_q && !q_status_i.full;
    in_stall_o = fr_valid_q && q_status_i.full;
    accept     = in_valid_i && !in_stall_o;
    is_matrix  = (in_data_i.command == CmdMatrixElem);
    last_col   = (COL_CNT_W'(col_pos_q) + COL_CNT_W'(1)) >= cols_eff;
    final_row  = (ROW_CNT_W'(row_pos_q) + ROW_CNT_W'(1)) >= rows_eff;

    tag_d.last_col     = last_col;
    tag_d.row_index    = row_pos_q;
    tag_d.final_row    = final_row;
    tag_d.prior_output = in_data_i.prior_output;

    load_pos_d = load_pos_q;
    col_pos_d  = col_pos_q;
    row_pos_d  = row_pos_q;
    fr_valid_d = fr_valid_q && !push;
    if (accept) begin
      if (!is_matrix) begin
        if ((COL_CNT_W'(load_pos_q) + COL_CNT_W'(1)) >= cols_eff) begin
          load_pos_d = '0;
        end else begin
          load_pos_d = load_pos_q + COL_IDX_W'(1);
        end
      end else begin
        fr_valid_d = 1'b1;
        if (last_col) begin
          col_pos_d = '0;
          row_pos_d = final_row ? '0 : row_pos_q + ROW_IDX_W'(1);
        end else begin
          col_pos_d = col_pos_q + COL_IDX_W'(1);
        end
      end
    end

    q_push_o.push               = push;
    q_push_o.entry.matrix_value = fr_value_q;
    q_push_o.entry.vector_value = rdata_q;
    q_push_o.entry.tag          = fr_tag_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_matrix) begin
      vec_mem[load_pos_q] <= in_data_i.value;
    end
    if (accept && is_matrix) begin
      rdata_q <= vec_mem[col_pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
      load_pos_q <= '0;
      col_pos_q  <= '0;
      row_pos_q  <= '0;
    end else begin
      fr_valid_q <= fr_valid_d;
      load_pos_q <= load_pos_d;
      col_pos_q  <= col_pos_d;
      row_pos_q  <= row_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_matrix) begin
      fr_value_q <= in_data_i.value;
      fr_tag_q   <= tag_d;
    end
  end

endmodule

// File: rtl/core/dmv_queue.sv
module dmv_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmv_pkg::q_push_t    q_push_i,
  output dmv_pkg::q_status_t  q_status_o,
  input  logic                pop_i,
  output dmv_pkg::q_entry_t   head_o
);
  import dmv_pkg::*;

  q_entry_t               slots_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   do_push;
  logic                   do_pop;

  always_comb begin
    q_status_o.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
    q_status_o.empty = (count_q == '0);
    do_push          = q_push_i.push;
    do_pop           = pop_i;
    head_o           = slots_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= q_push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_i.push |-> !q_status_o.full)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !q_status_o.empty)
    else $error("pop from empty queue");

endmodule

// File: rtl/core/dmv_back.sv
module dmv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmv_pkg::q_status_t  q_status_i,
  input  dmv_pkg::q_entry_t   head_i,
  output logic                pop_o,
  input  logic                accumulate_mode_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dmv_pkg::out_item_t  out_data_o
);
  import dmv_pkg::*;

  localparam logic signed [ACC_W-1:0]   RoundBias = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [TOTAL_W-1:0] SatMax = TOTAL_W'(32'sh7FFF_FFFF);
  localparam logic signed [TOTAL_W-1:0] SatMin = -(TOTAL_W'(1) << (OUT_W - 1));

  logic                     advance;
  logic                     p_valid_q;
  logic signed [PROD_W-1:0] prod_q;
  row_tag_t                 p_tag_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     s_valid_q;
  logic signed [ACC_W-1:0]  s_sum_q;
  row_tag_t                 s_tag_q;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic                     r_valid_q;
  logic signed [RND_W-1:0]  r_q;
  row_tag_t                 r_tag_q;
  logic signed [TOTAL_W-1:0] total;
  logic                     out_valid_q;
  out_item_t                out_q;
  out_item_t                out_d;

  always_comb begin
    advance = !(out_valid_q && out_stall_i);
    pop_o   = advance && !q_status_i.empty;
    acc_sum = acc_q + ACC_W'(prod_q);
    rnd_sum = s_sum_q + RoundBias;
    total   = TOTAL_W'(r_q);
    if (accumulate_mode_i) begin
      total = total + TOTAL_W'(r_tag_q.prior_output);
    end
    out_d.row_index = r_tag_q.row_index;
    out_d.final_row = r_tag_q.final_row;
    if (total > SatMax) begin
      out_d.row_sum   = SatMax[OUT_W-1:0];
      out_d.saturated = 1'b1;
    end else if (total < SatMin) begin
      out_d.row_sum   = SatMin[OUT_W-1:0];
      out_d.saturated = 1'b1;
    end else begin
      out_d.row_sum   = total[OUT_W-1:0];
      out_d.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      s_valid_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (advance) begin
      p_valid_q   <= pop_o;
      s_valid_q   <= p_valid_q && p_tag_q.last_col;
      r_valid_q   <= s_valid_q;
      out_valid_q <= r_valid_q;
      if (p_valid_q) begin
        acc_q <= p_tag_q.last_col ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (pop_o) begin
        prod_q  <= head_i.matrix_value * head_i.vector_value;
        p_tag_q <= head_i.tag;
      end
      if (p_valid_q && p_tag_q.last_col) begin
        s_sum_q <= acc_sum;
        s_tag_q <= p_tag_q;
      end
      if (s_valid_q) begin
        r_q     <= rnd_sum[ACC_W-1:FRAC_W];
        r_tag_q <= s_tag_q;
      end
      if (r_valid_q) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.saturated |->
      (out_q.row_sum == SatMax[OUT_W-1:0]) || (out_q.row_sum == SatMin[OUT_W-1:0]))
    else $error("saturated flag without clipped row sum");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && p_valid_q && p_tag_q.last_col |=> acc_q == '0)
    else $error("accumulator not cleared after row end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(r_valid_q))
    else $error("result without finished row");

endmodule

// File: rtl/core/dense_matrix_vector_multiply.sv
// Streaming y = M*x in Q1.23 fixed point. Send column_count beats with command 0 to
// load the vector, then the matrix row-major with command 1, one element per beat;
// the last beat of each row yields one result beat (Q9.23 rounded to nearest, ties up,
// prior_output added in accumulate mode, saturated with a flag). One beat is taken
// every cycle unless the input stalls; the front reads the vector store through its
// single port and parks the element in a four-entry queue, and the back multiplies,
// accumulates, rounds and saturates over four registered stages (product, sum,
// round, output). An output stall holds the whole back end; the queue then fills
// and the input stalls. The vector store has no reset: load an entry before using it.
module dense_matrix_vector_multiply (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dmv_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dmv_pkg::out_item_t                  out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmv_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [dmv_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [dmv_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import dmv_pkg::*;

  logic [COL_CNT_W-1:0] column_count_q;
  logic [ROW_CNT_W-1:0] row_count_q;
  logic                 accumulate_mode_q;
  logic                 reg_write;
  reg_idx_e             reg_idx;
  q_push_t              q_push;
  q_status_t            q_status;
  q_entry_t             q_head;
  logic                 q_pop;

  always_comb begin
    pready    = 1'b1;
    reg_write = psel && penable && pwrite && pready;
    reg_idx   = reg_idx_e'(paddr[3:2]);
    case (reg_idx)
      RegColumnCount: prdata = APB_DATA_W'(column_count_q);
      RegRowCount:    prdata = APB_DATA_W'(row_count_q);
      RegAccumulate:  prdata = APB_DATA_W'(accumulate_mode_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q    <= COL_CNT_W'(1);
      row_count_q       <= ROW_CNT_W'(1);
      accumulate_mode_q <= 1'b0;
    end else if (reg_write) begin
      case (reg_idx)
        RegColumnCount: column_count_q    <= pwdata[COL_CNT_W-1:0];
        RegRowCount:    row_count_q       <= pwdata[ROW_CNT_W-1:0];
        RegAccumulate:  accumulate_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  dmv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .column_count_i (column_count_q),
    .row_count_i    (row_count_q),
    .q_status_i     (q_status),
    .q_push_o       (q_push)
  );

  dmv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_push_i   (q_push),
    .q_status_o (q_status),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  dmv_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_status_i        (q_status),
    .head_i            (q_head),
    .pop_o             (q_pop),
    .accumulate_mode_i (accumulate_mode_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_data_o        (out_data_o)
  );

endmodule

// File: tb/sv/dmv_checker.sv
module dmv_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  dmv_pkg::in_item_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  dmv_pkg::out_item_t             out_data_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [dmv_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [dmv_pkg::APB_DATA_W-1:0] pwdata_i,
  output int unsigned                    rows_due_o,
  output int unsigned                    rows_checked_o,
  output int unsigned                    clipped_rows_o,
  output int unsigned                    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmv_pkg::*;

  localparam longint SumMax = 64'sd2147483647;
  localparam longint SumMin = -64'sd2147483648;

  logic signed [ELEM_W-1:0] vec_mem [MAX_COLUMNS];
  logic [COL_CNT_W-1:0]     n_cols;
  logic [ROW_CNT_W-1:0]     n_rows;
  logic                     acc_mode;
  int unsigned              load_ptr;
  int unsigned              col_ptr;
  int unsigned              row_ptr;
  longint                   dot_acc;
  out_item_t                row_sums_due [$];
  int unsigned              checked;
  int unsigned              clipped;
  int unsigned              bad;

  function automatic int unsigned cols_in_use();
    if (n_cols == 0) return 1;
    if (n_cols > MAX_COLUMNS) return MAX_COLUMNS;
    return 32'(n_cols);
  endfunction

  function automatic int unsigned rows_in_use();
    if (n_rows == 0) return 1;
    if (n_rows > MAX_ROWS) return MAX_ROWS;
    return 32'(n_rows);
  endfunction

  function automatic bit field_differs(input string name, input longint want, input longint got);
    if (want == got) return 1'b0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1'b1;
  endfunction

  task automatic predict_beat(input in_item_t beat);
    longint    rounded;
    out_item_t row;
    if (beat.command == CmdLoadVector) begin
      vec_mem[COL_IDX_W'(load_ptr)] = beat.value;
      load_ptr = (load_ptr + 1 >= cols_in_use()) ? 0 : load_ptr + 1;
    end else begin
      dot_acc += longint'(beat.value) * longint'(vec_mem[COL_IDX_W'(col_ptr)]);
      if (col_ptr + 1 < cols_in_use()) begin
        col_ptr++;
      end else begin
        // round to nearest, ties up, then drop the low 23 fraction bits
        rounded = (dot_acc + (longint'(1) <<< 22)) >>> 23;
        if (acc_mode) rounded += longint'(beat.prior_output);
        row.saturated = (rounded > SumMax) || (rounded < SumMin);
        if (rounded > SumMax) rounded = SumMax;
        if (rounded < SumMin) rounded = SumMin;
        row.row_sum   = OUT_W'(rounded);
        row.row_index = ROW_IDX_W'(row_ptr);
        row.final_row = (row_ptr + 1 >= rows_in_use());
        row_sums_due.push_back(row);
        row_ptr = row.final_row ? 0 : row_ptr + 1;
        dot_acc = 0;
        col_ptr = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      n_cols   = COL_CNT_W'(1);
      n_rows   = ROW_CNT_W'(1);
      acc_mode = 1'b0;
      load_ptr = 0;
      col_ptr  = 0;
      row_ptr  = 0;
      dot_acc  = 0;
      row_sums_due.delete();
      checked  = 0;
      clipped  = 0;
      bad      = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[APB_ADDR_W-1:2]))
          RegColumnCount: n_cols = pwdata_i[COL_CNT_W-1:0];
          RegRowCount:    n_rows = pwdata_i[ROW_CNT_W-1:0];
          RegAccumulate:  acc_mode = pwdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (row_sums_due.size() == 0) begin
          $error("row result beat with no expectation waiting (row_index %0d)",
                 out_data_i.row_index);
          bad++;
        end else begin
          want = row_sums_due.pop_front();
          if (field_differs("row_sum", longint'(want.row_sum),
                            longint'(out_data_i.row_sum)) |
              field_differs("row_index", longint'(want.row_index),
                            longint'(out_data_i.row_index)) |
              field_differs("final_row", longint'(want.final_row),
                            longint'(out_data_i.final_row)) |
              field_differs("saturated", longint'(want.saturated),
                            longint'(out_data_i.saturated))) begin
            bad++;
          end
          if (want.saturated) clipped++;
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) predict_beat(in_data_i);
    end
    rows_due_o     <= row_sums_due.size();
    rows_checked_o <= checked;
    clipped_rows_o <= clipped;
    mismatches_o   <= bad;
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dmv_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned RandomBeats = 850;
  localparam int unsigned WideCols    = 48;

  localparam logic [ELEM_W-1:0] MinElem  = 24'h800000;
  localparam logic [ELEM_W-1:0] MaxElem  = 24'h7FFFFF;
  localparam logic [ELEM_W-1:0] HalfLsb  = 24'h000800;
  localparam logic [OUT_W-1:0]  MinPrior = 32'h80000000;
  localparam logic [OUT_W-1:0]  MaxPrior = 32'h7FFFFFFF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned rows_due;
  int unsigned rows_checked;
  int unsigned clipped_rows;
  int unsigned mismatches;

  int unsigned beats_sent;
  int unsigned reg_writes;
  bit          sender_quiet;
  bit          receiver_quiet;
  bit          long_hold_req;

  dense_matrix_vector_multiply DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dmv_checker row_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .rows_due_o     (rows_due),
    .rows_checked_o (rows_checked),
    .clipped_rows_o (clipped_rows),
    .mismatches_o   (mismatches)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return MinElem;
      1: return MaxElem;
      2: return '0;
      3: return '1;
      4: return ELEM_W'($urandom_range(0, 4095));
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] rand_prior();
    case ($urandom_range(0, 7))
      0: return MinPrior;
      1: return MaxPrior;
      2: return MaxPrior - OUT_W'($urandom_range(0, 1 << 24));
      3: return MinPrior + OUT_W'($urandom_range(0, 1 << 24));
      default: return OUT_W'($urandom);
    endcase
  endfunction

  task automatic send_beat(input cmd_e cmd, input logic [ELEM_W-1:0] value,
                           input logic [OUT_W-1:0] prior);
    in_item_t    beat;
    int unsigned gap;
    beat.command      = cmd;
    beat.value        = value;
    beat.prior_output = prior;
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
    gap = sender_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    beats_sent++;
  endtask

  // drop valid and hold until every row result is in and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  task automatic configure(input int unsigned cols, input int unsigned rows, input bit acc);
    settle();
    write_reg(RegColumnCount, cols);
    write_reg(RegRowCount, rows);
    write_reg(RegAccumulate, APB_DATA_W'(acc));
  endtask

  task automatic run_matrix_pass(input int unsigned n_loads, input int unsigned n_elems);
    repeat (n_loads) send_beat(CmdLoadVector, rand_elem(), rand_prior());
    repeat (n_elems) begin
      if ($urandom_range(0, 7) == 0) send_beat(CmdLoadVector, rand_elem(), rand_prior());
      send_beat(CmdMatrixElem, rand_elem(), rand_prior());
    end
  endtask

  initial begin
    int unsigned wait_n;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_quiet = !receiver_quiet;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        wait_n = LongHold;
      end else begin
        wait_n = receiver_quiet ? 0 : $urandom_range(0, 4);
      end
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    int unsigned cols;
    int unsigned rows;
    int unsigned eff;
    int unsigned pick;
    int unsigned first;
    int unsigned random_beats;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    random_beats = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes of both operands, a load in the middle of a row, row wrap
    configure(2, 3, 1'b0);
    send_beat(CmdLoadVector, MinElem, '0);
    send_beat(CmdLoadVector, MaxElem, '0);
    send_beat(CmdMatrixElem, MinElem, MinPrior);
    send_beat(CmdLoadVector, HalfLsb, '0);
    send_beat(CmdMatrixElem, MinElem, MaxPrior);
    send_beat(CmdMatrixElem, MaxElem, '0);
    send_beat(CmdMatrixElem, MaxElem, '0);
    send_beat(CmdMatrixElem, '0, '0);
    send_beat(CmdMatrixElem, '1, '0);

    // shrink the vector under a stale load position; rounding ties both ways
    settle();
    write_reg(RegColumnCount, 1);
    write_reg(RegRowCount, 0);
    send_beat(CmdLoadVector, HalfLsb, '0);
    send_beat(CmdLoadVector, HalfLsb, '0);
    send_beat(CmdMatrixElem, HalfLsb, '0);
    send_beat(CmdMatrixElem, 24'hFFF800, '0);

    // accumulate into the prior output, clipping high and low
    settle();
    write_reg(RegColumnCount, 0);
    write_reg(RegRowCount, 2);
    write_reg(RegAccumulate, 1);
    send_beat(CmdLoadVector, MaxElem, '0);
    send_beat(CmdMatrixElem, MaxElem, MaxPrior);
    send_beat(CmdLoadVector, MinElem, '0);
    send_beat(CmdMatrixElem, MaxElem, MinPrior);
    send_beat(CmdMatrixElem, MinElem, 32'h7F800000);

    // fill every store entry that the widest random pass reads
    configure(WideCols, 3, 1'b1);
    run_matrix_pass(WideCols, 2 * WideCols + 7);

    // one result per beat while the receiver holds off: the block backs up
    configure(1, 5, 1'b0);
    long_hold_req = 1'b1;
    repeat (60) send_beat(CmdMatrixElem, rand_elem(), rand_prior());

    while (random_beats < RandomBeats) begin
      pick = $urandom_range(0, 31);
      cols = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, WideCols) : $urandom_range(1, 6);
      pick = $urandom_range(0, 31);
      rows = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(7, 8191) : $urandom_range(1, 6);
      configure(cols, rows, 1'($urandom_range(0, 1)));
      eff = (cols == 0) ? 1 : cols;
      first = beats_sent;
      run_matrix_pass($urandom_range(0, eff + 1),
                      eff * $urandom_range(1, 4) +
                      (($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : 0));
      if ($urandom_range(0, 4) == 0) begin
        settle();
        run_matrix_pass(0, eff);
      end
      random_beats += beats_sent - first;
    end

    settle();
    $display("Run: %0d beats sent across %0d register writes.", beats_sent, reg_writes);
    $display("Checked %0d row results, %0d of them clipped.", rows_checked, clipped_rows);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("Timeout after %0d cycles", LimitCycles);
    $display("Mismatches found");
    $finish;
  end

endmodule
